/* hdl/itrt_pkg.sv */
// Shared types, constants and helper functions for the integer to radix text block.
// No dependencies; imported by every module of the block and by its checker.
`default_nettype none

package itrt_pkg;

  // Operand width used internally and the fixed port widths.
  localparam int VALUE_BITS = 32;
  localparam int IN_VALUE_W = 32;
  localparam int BASE_W     = 6;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 6;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(VALUE_BITS);
  localparam int STEP_W     = $clog2(VALUE_BITS);

  // Radix limits and the one radix that honors a sign.
  localparam logic [BASE_W-1:0] MIN_BASE = 6'd2;
  localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;
  localparam logic [BASE_W-1:0] DEC_BASE = 6'd10;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_STORE,
    ST_CHECK,
    ST_SIGN,
    ST_READ,
    ST_EMIT,
    ST_BAD
  } itrt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic store;
    logic sign_load;
    logic rd;
    logic emit;
    logic bad_load;
  } itrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic neg;
    logic div_done;
    logic q_zero;
    logic cnt_full;
    logic last_digit;
    logic out_free;
  } itrt_sts_t;

  // Maps a digit value below 36 to its character, 0-9 then A-Z.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end else begin
      return CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/itrt_ctrl.sv */
// Controller state machine for the integer to radix text block.
// Depends on itrt_pkg; drives the datapath through itrt_cmd_t and reads itrt_sts_t.
`default_nettype none

module itrt_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  itrt_pkg::itrt_sts_t sts,
  output itrt_pkg::itrt_cmd_t cmd
);
  import itrt_pkg::*;

  itrt_state_t state_r;
  itrt_state_t state_nxt;
  logic        more_digits;

  // Another division pass is needed while the quotient is nonzero and room remains.
  assign more_digits = !sts.q_zero && !sts.cnt_full;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = sts.bad ? ST_BAD : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_STORE;
      end
      ST_STORE: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (more_digits) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = sts.neg ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (sts.out_free) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = sts.last_digit ? ST_IDLE : ST_READ;
      end
      ST_BAD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output logic.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
      end
      ST_CHECK: begin
        cmd.div_init = more_digits;
      end
      ST_SIGN: begin
        cmd.sign_load = sts.out_free;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      ST_BAD: begin
        cmd.bad_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/itrt_dp.sv */
// Datapath for the integer to radix text block: operand prep, shift-subtract
// divider, digit memory and output register. Depends on itrt_pkg.
`default_nettype none

module itrt_dp (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [itrt_pkg::IN_VALUE_W-1:0]   in_value,
  input  wire  [itrt_pkg::BASE_W-1:0]       in_base,
  input  wire                               in_is_signed,
  input  itrt_pkg::itrt_cmd_t               cmd,
  output itrt_pkg::itrt_sts_t               sts,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [itrt_pkg::CHAR_W-1:0]       out_character,
  output logic                              out_last,
  output logic                              out_bad_base
);
  import itrt_pkg::*;

  // Working registers.
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [BASE_W-1:0]     base_r, base_nxt;
  logic                  neg_r, neg_nxt;
  logic                  bad_r, bad_nxt;
  logic [DIGIT_W-1:0]    rd_data_r;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_bad_r, out_bad_nxt;

  // Digit memory, least significant digit first.
  logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];

  // Operand preparation.
  logic [VALUE_BITS-1:0] v_in;
  logic                  neg_in;
  logic                  bad_in;
  logic [VALUE_BITS-1:0] mag_in;

  // One divider step.
  logic [DIGIT_W:0]      trial;
  logic                  trial_ge;
  logic [DIGIT_W-1:0]    rem_step;

  logic [IDX_W-1:0]      rd_idx;
  logic                  out_free;
  logic                  out_load;

  // The magnitude is formed unsigned, so the most negative value is handled too.
  always_comb begin
    v_in   = VALUE_BITS'(in_value);
    neg_in = in_is_signed && (in_base == DEC_BASE) && v_in[VALUE_BITS-1];
    bad_in = (in_base < MIN_BASE) || (in_base > MAX_BASE);
    mag_in = neg_in ? (VALUE_BITS'(0) - v_in) : v_in;
  end

  // Restoring division: one quotient bit per cycle, quotient shifted in place.
  always_comb begin
    trial    = {rem_r, q_r[VALUE_BITS-1]};
    trial_ge = trial >= {1'b0, base_r};
    rem_step = trial_ge ? DIGIT_W'(trial - {1'b0, base_r}) : DIGIT_W'(trial);
  end

  assign rd_idx   = IDX_W'(cnt_r - CNT_W'(1));
  assign out_free = !out_valid_r || out_ready;
  assign out_load = cmd.sign_load || cmd.emit || cmd.bad_load;

  // Next values of the working registers.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    base_nxt = base_r;
    neg_nxt  = neg_r;
    bad_nxt  = bad_r;
    if (cmd.load) begin
      q_nxt    = mag_in;
      rem_nxt  = '0;
      step_nxt = '0;
      cnt_nxt  = '0;
      base_nxt = in_base;
      neg_nxt  = neg_in;
      bad_nxt  = bad_in;
    end
    if (cmd.div_init) begin
      rem_nxt  = '0;
      step_nxt = '0;
    end
    if (cmd.div_step) begin
      q_nxt    = {q_r[VALUE_BITS-2:0], trial_ge};
      rem_nxt  = rem_step;
      step_nxt = step_r + STEP_W'(1);
    end
    if (cmd.store) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.emit) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Next values of the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
    if (cmd.sign_load) begin
      out_char_nxt = CHAR_MINUS;
      out_last_nxt = 1'b0;
      out_bad_nxt  = 1'b0;
    end
    if (cmd.emit) begin
      out_char_nxt = digit_char(rd_data_r);
      out_last_nxt = (cnt_r == CNT_W'(1));
      out_bad_nxt  = 1'b0;
    end
    if (cmd.bad_load) begin
      out_char_nxt = CHAR_NONE;
      out_last_nxt = 1'b1;
      out_bad_nxt  = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    bad_r      <= bad_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  // Digit memory write port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      digit_mem[cnt_r[IDX_W-1:0]] <= rem_r;
    end
  end

  // Digit memory registered read port.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= digit_mem[rd_idx];
    end
  end

  // Status to the controller.
  always_comb begin
    sts.bad        = bad_r;
    sts.neg        = neg_r;
    sts.div_done   = (step_r == STEP_W'(VALUE_BITS - 1));
    sts.q_zero     = (q_r == '0);
    sts.cnt_full   = (cnt_r == CNT_W'(VALUE_BITS));
    sts.last_digit = (cnt_r == CNT_W'(1));
    sts.out_free   = out_free;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_bad_base  = out_bad_r;

endmodule

`default_nettype wire

/* hdl/integer_to_radix_text.sv */
// Top level of the integer to radix text block: controller plus datapath.
// Depends on itrt_pkg, itrt_ctrl and itrt_dp.
//
// Converts one 32-bit word per transaction into ASCII text in a base from 2 to 36,
// most significant digit first, digits 0-9 then A-Z, one output transaction per
// character with out_last on the final one. A minus sign leads only for signed
// negative values in base 10; other bases print the raw bit pattern. A base
// outside 2..36 yields one transaction with out_bad_base set, character 0 and
// out_last set. Conversions run one at a time. Each digit takes one full pass of
// the single shared shift-subtract divider over all 32 quotient bits, then a store
// and a check; each character then takes a digit memory read and an output load,
// and a leading minus sign is loaded into the output register before the first
// digit is read. The next input is accepted once the last character sits in the
// output register.
`default_nettype none

module integer_to_radix_text (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [itrt_pkg::IN_VALUE_W-1:0]   in_value,
  input  wire  [itrt_pkg::BASE_W-1:0]       in_base,
  input  wire                               in_is_signed,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [itrt_pkg::CHAR_W-1:0]       out_character,
  output logic                              out_last,
  output logic                              out_bad_base
);
  import itrt_pkg::*;

  itrt_cmd_t cmd;
  itrt_sts_t sts;

  // Sequencing of load, divide, store and emit.
  itrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Divider, digit memory and output register.
  itrt_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .in_base       (in_base),
    .in_is_signed  (in_is_signed),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .out_bad_base  (out_bad_base)
  );

endmodule

`default_nettype wire

/* hdl/itrt_checker.sv */
// Port-level checker for the integer to radix text block and its bind statement.
// Depends on itrt_pkg and the top level integer_to_radix_text.
`default_nettype none

module itrt_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire  [itrt_pkg::CHAR_W-1:0]       out_character,
  input wire                               out_last,
  input wire                               out_bad_base
);
  import itrt_pkg::*;

  // A bad-base transaction is a lone terminator with a null character.
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_base |-> out_last && (out_character == CHAR_NONE))
    else $error("bad-base transaction is not a null last character");

  // Every good character is a digit, an upper-case letter or the minus sign.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_base |->
      ((out_character >= CHAR_ZERO) && (out_character <= CHAR_NINE)) ||
      ((out_character >= CHAR_UPPER_A) && (out_character <= CHAR_UPPER_Z)) ||
      (out_character == CHAR_MINUS))
    else $error("output character outside the digit set");

  // The sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_base && (out_character == CHAR_MINUS) |-> !out_last)
    else $error("minus sign marked as last character");

  // One conversion at a time: a new input is not taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in back-to-back cycles");

  // A stalled output transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) &&
      $stable(out_last) && $stable(out_bad_base))
    else $error("stalled output transaction changed");

endmodule

bind integer_to_radix_text itrt_checker u_itrt_checker (.*);

`default_nettype wire
